// File: sv/aci_pkg.sv
// ----------------------------------------------------------------------------
// aci_pkg
// Types, table codes and coefficient tables shared by the airfoil
// coefficient interpolator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aci_pkg;

  typedef struct packed {
    logic signed [15:0] attack_angle;
    logic signed [15:0] flap_setting;
    logic               mode;
  } aci_in_t;

  typedef struct packed {
    logic signed [15:0] lift_coeff;
    logic        [13:0] drag_coeff;
    logic               stall_res;
  } aci_out_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    logic        mode;
    logic        lift_ok;
    logic        drag_ok;
    logic        neg;       // rudder: mirror lift sign
    logic        flap_neg;  // blend toward flap-down curve
    logic [14:0] flap_mag;  // 0..16384, forced to 0 for the rudder
    logic [3:0]  lidx;
    logic [9:0]  lfrac;
    logic [3:0]  didx;
    logic [9:0]  dfrac;
  } aci_job_t;

  typedef enum logic [2:0] {
    TAB_LIFT_PLAIN,
    TAB_LIFT_DOWN,
    TAB_LIFT_UP,
    TAB_DRAG_PLAIN,
    TAB_DRAG_DOWN,
    TAB_DRAG_UP,
    TAB_RUD_LIFT,
    TAB_RUD_DRAG
  } aci_tab_t;

  localparam int NUM_LANES = 6;  // lift plain/down/up, drag plain/down/up

  localparam logic signed [16:0] CAMB_LIFT_LO = -17'sd3072;
  localparam logic signed [16:0] CAMB_DRAG_LO = -17'sd2048;
  localparam logic signed [16:0] TABLE_HI     = 17'sd6144;
  localparam logic        [16:0] TABLE_HI_U   = 17'd6144;
  localparam logic        [14:0] ONE_Q14      = 15'd16384;
  localparam logic signed [15:0] LIFT_SCALE   = 16'sd14746;
  localparam logic        [13:0] CAMB_DRAG_OUT = 14'd6144;
  localparam logic        [13:0] RUD_DRAG_OUT  = 14'd12288;
  localparam logic signed [19:0] LIFT_MAX = 20'sd32767;
  localparam logic signed [19:0] LIFT_MIN = -20'sd32768;
  localparam logic signed [17:0] DRAG_MAX = 18'sd16383;

  function automatic aci_tab_t lane_tab(input int lane, input logic mode);
    aci_tab_t t;
    case (lane)
      0:       t = mode ? TAB_RUD_LIFT : TAB_LIFT_PLAIN;
      1:       t = TAB_LIFT_DOWN;
      2:       t = TAB_LIFT_UP;
      3:       t = mode ? TAB_RUD_DRAG : TAB_DRAG_PLAIN;
      4:       t = TAB_DRAG_DOWN;
      default: t = TAB_DRAG_UP;
    endcase
    return t;
  endfunction

  // Coefficients in Q2.14; unused indexes read zero
  function automatic logic signed [15:0] coef(input aci_tab_t tab, input logic [3:0] idx);
    logic signed [15:0] v;
    v = '0;
    case (tab)
      TAB_LIFT_PLAIN: begin
        case (idx)
          4'd0: v = -16'sd13926;  4'd1: v = -16'sd8847;
          4'd2: v = -16'sd3277;   4'd3: v = 16'sd3277;
          4'd4: v = 16'sd9339;    4'd5: v = 16'sd15073;
          4'd6: v = 16'sd19825;   4'd7: v = 16'sd23429;
          4'd8: v = 16'sd22938;   4'd9: v = 16'sd16384;
          default: v = '0;
        endcase
      end
      TAB_LIFT_DOWN: begin
        case (idx)
          4'd0: v = -16'sd8192;   4'd1: v = 16'sd0;
          4'd2: v = 16'sd7373;    4'd3: v = 16'sd13926;
          4'd4: v = 16'sd16712;   4'd5: v = 16'sd22774;
          4'd6: v = 16'sd27034;   4'd7: v = 16'sd28672;
          4'd8: v = 16'sd22610;   4'd9: v = 16'sd19169;
          default: v = '0;
        endcase
      end
      TAB_LIFT_UP: begin
        case (idx)
          4'd0: v = -16'sd18022;  4'd1: v = -16'sd12124;
          4'd2: v = -16'sd6554;   4'd3: v = 16'sd0;
          4'd4: v = 16'sd4424;    4'd5: v = 16'sd10322;
          4'd6: v = 16'sd15073;   4'd7: v = 16'sd16876;
          4'd8: v = 16'sd18022;   4'd9: v = 16'sd12780;
          default: v = '0;
        endcase
      end
      TAB_DRAG_PLAIN: begin
        case (idx)
          4'd0: v = 16'sd164;  4'd1: v = 16'sd121;  4'd2: v = 16'sd66;
          4'd3: v = 16'sd147;  4'd4: v = 16'sd213;  4'd5: v = 16'sd377;
          4'd6: v = 16'sd819;  4'd7: v = 16'sd1966; 4'd8: v = 16'sd3441;
          default: v = '0;
        endcase
      end
      TAB_DRAG_DOWN: begin
        case (idx)
          4'd0: v = 16'sd106;  4'd1: v = 16'sd70;   4'd2: v = 16'sd90;
          4'd3: v = 16'sd251;  4'd4: v = 16'sd362;  4'd5: v = 16'sd641;
          4'd6: v = 16'sd1638; 4'd7: v = 16'sd3195; 4'd8: v = 16'sd4915;
          default: v = '0;
        endcase
      end
      TAB_DRAG_UP: begin
        case (idx)
          4'd0: v = 16'sd82;   4'd1: v = 16'sd70;   4'd2: v = 16'sd90;
          4'd3: v = 16'sd426;  4'd4: v = 16'sd616;  4'd5: v = 16'sd1089;
          4'd6: v = 16'sd2130; 4'd7: v = 16'sd2949; 4'd8: v = 16'sd4096;
          default: v = '0;
        endcase
      end
      TAB_RUD_LIFT: begin
        case (idx)
          4'd0: v = 16'sd2621;  4'd1: v = 16'sd7471;  4'd2: v = 16'sd12059;
          4'd3: v = 16'sd15860; 4'd4: v = 16'sd18743; 4'd5: v = 16'sd18350;
          4'd6: v = 16'sd13107;
          default: v = '0;
        endcase
      end
      TAB_RUD_DRAG: begin
        case (idx)
          4'd0: v = 16'sd52;   4'd1: v = 16'sd118;  4'd2: v = 16'sd170;
          4'd3: v = 16'sd301;  4'd4: v = 16'sd655;  4'd5: v = 16'sd1573;
          4'd6: v = 16'sd2753;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/aci_front.sv
// ----------------------------------------------------------------------------
// aci_front
// Accepts items, checks table ranges, splits the angle into segment index
// and fraction, saturates the flap, and pushes the job into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aci_front import aci_pkg::*; (
  input  logic     item_valid,
  output logic     item_stall,
  input  aci_in_t  item,
  input  logic     full,
  output logic     push,
  output aci_job_t job
);

  logic signed [16:0] ang;
  logic        [16:0] aa;
  logic        [16:0] loff;
  logic        [16:0] doff;
  logic signed [16:0] flap;
  logic signed [16:0] flap_sat;
  logic        [16:0] flap_abs;
  logic               rud_ok;

  assign item_stall = full;
  assign push       = item_valid && !full;

  always_comb begin
    ang      = 17'(item.attack_angle);
    aa       = ang[16] ? 17'(-ang) : ang;
    loff     = 17'(ang - CAMB_LIFT_LO);
    doff     = 17'(ang - CAMB_DRAG_LO);
    flap     = 17'(item.flap_setting);
    if (flap > 17'sd16384) begin
      flap_sat = 17'sd16384;
    end else if (flap < -17'sd16384) begin
      flap_sat = -17'sd16384;
    end else begin
      flap_sat = flap;
    end
    flap_abs = flap_sat[16] ? 17'(-flap_sat) : flap_sat;
    rud_ok   = aa < TABLE_HI_U;

    job.mode = item.mode;
    if (!item.mode) begin
      job.lift_ok  = (ang >= CAMB_LIFT_LO) && (ang < TABLE_HI);
      job.drag_ok  = (ang >= CAMB_DRAG_LO) && (ang < TABLE_HI);
      job.neg      = 1'b0;
      job.flap_neg = flap_sat[16];
      job.flap_mag = flap_abs[14:0];
      job.lidx     = loff[13:10];
      job.lfrac    = loff[9:0];
      job.didx     = {1'b0, doff[12:10]};
      job.dfrac    = doff[9:0];
    end else begin
      // symmetric surface: interpolate on |angle|, plain curve only
      job.lift_ok  = rud_ok;
      job.drag_ok  = rud_ok;
      job.neg      = ang[16];
      job.flap_neg = 1'b0;
      job.flap_mag = '0;
      job.lidx     = {1'b0, aa[12:10]};
      job.lfrac    = aa[9:0];
      job.didx     = {1'b0, aa[12:10]};
      job.dfrac    = aa[9:0];
    end
  end

endmodule

// File: sv/aci_queue.sv
// ----------------------------------------------------------------------------
// aci_queue
// Small FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aci_queue import aci_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  aci_job_t wdata,
  output logic     full,
  input  logic     pop,
  output aci_job_t rdata,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  aci_job_t        mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == FULL_CNT;
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/aci_back.sv
// ----------------------------------------------------------------------------
// aci_back
// Four register stages: segment interpolation products, blend products,
// lift scaling, then range handling and saturation into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aci_back import aci_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     empty,
  input  aci_job_t job,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output aci_out_t result
);

  logic adv;

  // stage A: base point and slope product per lane
  logic               va;
  aci_job_t           ja;
  logic signed [15:0] base_a [NUM_LANES];
  logic signed [27:0] prod_a [NUM_LANES];
  logic signed [15:0] base_next [NUM_LANES];
  logic signed [27:0] prod_next [NUM_LANES];

  // stage B: blend products
  logic               vb;
  aci_job_t           jb;
  logic signed [32:0] lc_b, lp_b, dc_b, dp_b;
  logic signed [16:0] v [NUM_LANES];
  logic        [14:0] mc;

  // stage C: scaled lift, drag halved in cambered mode
  logic               vc;
  aci_job_t           jc;
  logic signed [33:0] lift_c;
  logic signed [17:0] drag_c;
  logic signed [33:0] lsum, dsum;
  logic signed [17:0] cl, cd;

  // output stage
  logic signed [19:0] lf;
  aci_out_t           res_next;

  assign adv = !(result_valid && result_stall);
  assign pop = adv && !empty;

  always_comb begin
    logic [3:0] i;
    logic [9:0] f;
    aci_tab_t   t;
    logic signed [16:0] diff;
    for (int l = 0; l < NUM_LANES; l++) begin
      i = (l < 3) ? job.lidx : job.didx;
      f = (l < 3) ? job.lfrac : job.dfrac;
      t = lane_tab(l, job.mode);
      diff = 17'(coef(t, i + 4'd1)) - 17'(coef(t, i));
      base_next[l] = coef(t, i);
      prod_next[l] = diff * $signed({1'b0, f});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ja <= job;
      for (int l = 0; l < NUM_LANES; l++) begin
        base_a[l] <= base_next[l];
        prod_a[l] <= prod_next[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      v[l] = 17'(base_a[l]) + 17'(prod_a[l] >>> 10);
    end
    mc = 15'(ONE_Q14 - ja.flap_mag);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jb   <= ja;
      lc_b <= $signed({1'b0, ja.flap_mag}) * (ja.flap_neg ? v[1] : v[2]);
      lp_b <= $signed({1'b0, mc}) * v[0];
      dc_b <= $signed({1'b0, ja.flap_mag}) * (ja.flap_neg ? v[4] : v[5]);
      dp_b <= $signed({1'b0, mc}) * v[3];
    end
  end

  always_comb begin
    lsum = 34'(lc_b) + 34'(lp_b);
    dsum = 34'(dc_b) + 34'(dp_b);
    cl   = 18'(lsum >>> 14);
    cd   = 18'(dsum >>> 14);
  end

  // rudder lift skips the 0.9 scale: pre-shift so the next >>> 14 restores it
  always_ff @(posedge clk) begin
    if (adv) begin
      jc     <= jb;
      lift_c <= jb.mode ? 34'($signed({cl, 14'b0})) : cl * LIFT_SCALE;
      drag_c <= jb.mode ? cd : (cd >>> 1);
    end
  end

  always_comb begin
    lf = 20'(lift_c >>> 14);
    if (!jc.lift_ok) begin
      lf = '0;
    end else if (jc.neg) begin
      lf = -lf;
    end
    if (lf > LIFT_MAX) begin
      res_next.lift_coeff = 16'(LIFT_MAX);
    end else if (lf < LIFT_MIN) begin
      res_next.lift_coeff = 16'(LIFT_MIN);
    end else begin
      res_next.lift_coeff = 16'(lf);
    end
    if (!jc.drag_ok) begin
      res_next.drag_coeff = jc.mode ? RUD_DRAG_OUT : CAMB_DRAG_OUT;
    end else if (drag_c < 0) begin
      res_next.drag_coeff = '0;
    end else if (drag_c > DRAG_MAX) begin
      res_next.drag_coeff = 14'(DRAG_MAX);
    end else begin
      res_next.drag_coeff = 14'(drag_c);
    end
    res_next.stall_res = res_next.lift_coeff == '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      va           <= pop;
      vb           <= va;
      vc           <= vb;
      result_valid <= vc;
    end
  end

endmodule

// File: sv/airfoil_coefficient_interpolator_core.sv
// ----------------------------------------------------------------------------
// airfoil_coefficient_interpolator_core
// Lift, drag and stall flag from attack angle, flap and surface mode.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result per item, in order. With
// the queue empty an accepted item is held in the queue, then passes the
// slope-product, blend-product and lift-scale stages, the last feeding the
// output register. While the output is stalled the back stages hold and
// the queue (QDEPTH items) keeps taking items; the input stalls only when
// the queue is full. Rate and latency are set by the four-stage back
// pipeline, whose widest step is one 18x16 multiply.
`timescale 1ns / 1ps

module airfoil_coefficient_interpolator_core import aci_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  aci_in_t  item,
  output logic     result_valid,
  input  logic     result_stall,
  output aci_out_t result
);

  aci_job_t job_in;
  aci_job_t job_out;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  aci_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .job        (job_in)
  );

  aci_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  aci_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .job          (job_out),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: sv/aci_checker.sv
// ----------------------------------------------------------------------------
// aci_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aci_checker import aci_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     item_valid,
  input logic     item_stall,
  input aci_in_t  item,
  input logic     result_valid,
  input logic     result_stall,
  input aci_out_t result
);

  // a stalled item stays put
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("item changed while stalled");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_stall_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.stall_res == (result.lift_coeff == '0))
    else $error("stall flag does not match lift");

  a_drag_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.drag_coeff <= RUD_DRAG_OUT)
    else $error("drag above its largest value");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind airfoil_coefficient_interpolator_core aci_checker u_aci_checker (.*);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for airfoil_coefficient_interpolator_core.
// ----------------------------------------------------------------------------
// A short table of directed items covers the edges of each angle range, the
// flap extremes and both surface modes. About 900 random items follow, most
// of them inside the table region. Every accepted item that has no listed
// result gets its expected lift, drag and stall flag from an in-bench
// interpolator. Results are checked in order as they leave the block. The
// sender runs in random bursts and the receiver stalls on patterns of its
// own. One long receiver hold fills the block so that it stalls its input.
`timescale 1ns / 1ps

module tb import aci_pkg::*;;

  localparam logic MODE_CAMBERED = 1'b0;
  localparam logic MODE_RUDDER   = 1'b1;

  // Q7.8 angle limits and Q2.14 constants
  localparam int LIFT_LO_Q8   = -3072;  // -12 deg
  localparam int DRAG_LO_Q8   = -2048;  // -8 deg
  localparam int ANGLE_END_Q8 = 6144;   // 24 deg
  localparam int UNITY_Q14    = 16384;
  localparam int SCALE_09_Q14 = 14746;
  localparam int CAMB_DRAG_OFF = 6144;
  localparam int RUD_DRAG_OFF  = 12288;

  localparam int NUM_RANDOM  = 900;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 20;
  localparam int LONG_HOLD   = 120;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_stall;
  aci_in_t  item;
  logic     result_valid;
  logic     result_stall;
  aci_out_t result;

  airfoil_coefficient_interpolator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Curve points in Q2.14, 4 deg apart, indexed by table code; short curves padded
  int curve_q14 [0:7][0:9] = '{
    '{-13926, -8847, -3277, 3277, 9339, 15073, 19825, 23429, 22938, 16384},
    '{-8192, 0, 7373, 13926, 16712, 22774, 27034, 28672, 22610, 19169},
    '{-18022, -12124, -6554, 0, 4424, 10322, 15073, 16876, 18022, 12780},
    '{164, 121, 66, 147, 213, 377, 819, 1966, 3441, 0},
    '{106, 70, 90, 251, 362, 641, 1638, 3195, 4915, 0},
    '{82, 70, 90, 426, 616, 1089, 2130, 2949, 4096, 0},
    '{2621, 7471, 12059, 15860, 18743, 18350, 13107, 0, 0, 0},
    '{52, 118, 170, 301, 655, 1573, 2753, 0, 0, 0}
  };

  aci_out_t pending_coeffs [$];
  aci_in_t  vec_item [$];
  bit       vec_known [$];
  aci_out_t vec_coeffs [$];

  int err_count  = 0;
  int items_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int curve_at(input aci_tab_t tab, input int off);
    int i;
    int d;
    i = off >>> 10;
    d = off & 1023;
    return curve_q14[tab][i] + (((curve_q14[tab][i+1] - curve_q14[tab][i]) * d) >>> 10);
  endfunction

  // Flap < 0 pulls toward the flap-down curve, otherwise toward flap-up
  function automatic int flap_mix(input int plain, input int down, input int up,
                                  input int flap);
    int m;
    int c;
    m = (flap < 0) ? -flap : flap;
    c = (flap < 0) ? down : up;
    return (m * c + (UNITY_Q14 - m) * plain) >>> 14;
  endfunction

  function automatic aci_out_t predict_coeffs(input aci_in_t it);
    aci_out_t r;
    int ang;
    int flap;
    int aa;
    int off;
    int lift;
    int drag;
    ang  = it.attack_angle;
    flap = it.flap_setting;
    if (flap > UNITY_Q14) flap = UNITY_Q14;
    if (flap < -UNITY_Q14) flap = -UNITY_Q14;
    lift = 0;
    if (it.mode == MODE_CAMBERED) begin
      if (ang >= LIFT_LO_Q8 && ang < ANGLE_END_Q8) begin
        off  = ang - LIFT_LO_Q8;
        lift = flap_mix(curve_at(TAB_LIFT_PLAIN, off), curve_at(TAB_LIFT_DOWN, off),
                        curve_at(TAB_LIFT_UP, off), flap);
        lift = (lift * SCALE_09_Q14) >>> 14;
      end
      if (ang >= DRAG_LO_Q8 && ang < ANGLE_END_Q8) begin
        off  = ang - DRAG_LO_Q8;
        drag = flap_mix(curve_at(TAB_DRAG_PLAIN, off), curve_at(TAB_DRAG_DOWN, off),
                        curve_at(TAB_DRAG_UP, off), flap) >>> 1;
      end else begin
        drag = CAMB_DRAG_OFF;
      end
    end else begin
      aa = (ang < 0) ? -ang : ang;
      if (aa < ANGLE_END_Q8) begin
        lift = curve_at(TAB_RUD_LIFT, aa);
        if (ang < 0) lift = -lift;
        drag = curve_at(TAB_RUD_DRAG, aa);
      end else begin
        drag = RUD_DRAG_OFF;
      end
    end
    if (lift > 32767) lift = 32767;
    if (lift < -32768) lift = -32768;
    if (drag > 16383) drag = 16383;
    if (drag < 0) drag = 0;
    r.lift_coeff = lift[15:0];
    r.drag_coeff = drag[13:0];
    r.stall_res  = (lift == 0);
    return r;
  endfunction

  function automatic aci_in_t random_item();
    aci_in_t it;
    int ang;
    int flap;
    int pick;
    it.mode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick >= 7)
      ang = int'($urandom_range(0, 46080)) - 23040;
    else if (it.mode == MODE_RUDDER)
      ang = int'($urandom_range(0, 12799)) - 6400;
    else
      ang = int'($urandom_range(0, 9599)) - 3328;  // table region plus a margin
    case ($urandom_range(0, 9))
      0:       flap = 0;
      1:       flap = UNITY_Q14;
      2:       flap = -UNITY_Q14;
      default: flap = int'($urandom_range(0, 32768)) - UNITY_Q14;
    endcase
    it.attack_angle = ang[15:0];
    it.flap_setting = flap[15:0];
    return it;
  endfunction

  task automatic add_vector(input int ang, input int flap, input logic mode, input bit known,
                            input int lift, input int drag, input logic stall);
    aci_in_t  it;
    aci_out_t want;
    it.attack_angle = ang[15:0];
    it.flap_setting = flap[15:0];
    it.mode         = mode;
    want.lift_coeff = lift[15:0];
    want.drag_coeff = drag[13:0];
    want.stall_res  = stall;
    vec_item.push_back(it);
    vec_known.push_back(known);
    vec_coeffs.push_back(want);
  endtask

  // Offers one item, honoring the burst/gap pattern, and books its result
  task automatic send_item(input aci_in_t it, input bit known, input aci_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 16);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_coeffs.push_back(known ? want : predict_coeffs(it));
    burst_left--;
    items_sent++;
  endtask

  // Receiver stall patterns, plus one long hold once traffic is flowing
  initial begin
    int seg;
    int kind;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && items_sent > 300) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        seg  = $urandom_range(10, 80);
        kind = $urandom_range(0, 3);
        repeat (seg) begin
          case (kind)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 9) < 3);
            2:       result_stall <= ($urandom_range(0, 9) < 8);
            default: result_stall <= ((seg % 3) == 0);
          endcase
          seg--;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    aci_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_coeffs.size() == 0) begin
        $error("unexpected result: lift_coeff %0d drag_coeff %0d stall_res %0d",
               result.lift_coeff, result.drag_coeff, result.stall_res);
        err_count++;
      end else begin
        want = pending_coeffs.pop_front();
        if (result.lift_coeff !== want.lift_coeff) begin
          $error("lift_coeff: expected %0d, actual %0d", want.lift_coeff, result.lift_coeff);
          err_count++;
        end
        if (result.drag_coeff !== want.drag_coeff) begin
          $error("drag_coeff: expected %0d, actual %0d", want.drag_coeff, result.drag_coeff);
          err_count++;
        end
        if (result.stall_res !== want.stall_res) begin
          $error("stall_res: expected %0d, actual %0d", want.stall_res, result.stall_res);
          err_count++;
        end
      end
    end
  end

  // Ends the run if no item moves on either side for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        idle = 0;
      else
        idle++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int n;
    aci_out_t none;
    none = '0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    //          angle   flap    mode           known lift  drag   stall
    add_vector(-23040,      0, MODE_CAMBERED, 1,     0,  6144, 1);
    add_vector( 23040,  16384, MODE_CAMBERED, 1,     0,  6144, 1);
    add_vector( 23040,      0, MODE_RUDDER,   1,     0, 12288, 1);
    add_vector(-23040, -16384, MODE_RUDDER,   1,     0, 12288, 1);
    add_vector(  6144,      0, MODE_RUDDER,   1,     0, 12288, 1);
    add_vector( -6144,      0, MODE_RUDDER,   1,     0, 12288, 1);
    add_vector(     0,      0, MODE_RUDDER,   1,  2621,    52, 0);
    add_vector(     0, -16384, MODE_RUDDER,   1,  2621,    52, 0);
    add_vector(     0,      0, MODE_CAMBERED, 1,  2949,    33, 0);
    add_vector(     0,  16384, MODE_CAMBERED, 1,     0,    45, 1);
    add_vector( -3073,      0, MODE_CAMBERED, 1,     0,  6144, 1);
    add_vector(  6144,  16384, MODE_CAMBERED, 1,     0,  6144, 1);
    add_vector(  6143,      0, MODE_RUDDER,   0,     0,     0, 0);
    add_vector(  -256,  16384, MODE_RUDDER,   0,     0,     0, 0);
    add_vector( -6143,      0, MODE_RUDDER,   0,     0,     0, 0);
    add_vector(  3000, -16384, MODE_RUDDER,   0,     0,     0, 0);
    add_vector( -3072,      0, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector( -2049, -16384, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector( -2048,      0, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector(  6143, -16384, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector(  6143,  16384, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector(     0, -16384, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector(  1000,   8192, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector( -1000,  -5000, MODE_CAMBERED, 0,     0,     0, 0);
    add_vector(  5000,     -1, MODE_CAMBERED, 0,     0,     0, 0);

    for (n = 0; n < vec_item.size(); n++)
      send_item(vec_item[n], vec_known[n], vec_coeffs[n]);
    for (n = 0; n < NUM_RANDOM; n++)
      send_item(random_item(), 1'b0, none);
    item_valid <= 1'b0;

    wait (pending_coeffs.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
